// ----- design/kmpsm_pkg.sv -----
// ---------------------------------------------------------------------------
// kmpsm_pkg
// Shared types and codes for the streaming KMP matcher: beat structs,
// function and error codes, and the sequencer states.
// ---------------------------------------------------------------------------
package kmpsm_pkg;

    // Function codes of an input beat
    localparam logic [1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [1:0] FUNC_APPEND = 2'd1;
    localparam logic [1:0] FUNC_TEXT   = 2'd2;

    // Error codes of a result beat
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_FULL  = 2'd1;
    localparam logic [1:0] ERR_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] data_byte;
    } t_in;

    typedef struct packed {
        logic        match;
        logic [31:0] match_start;
        logic [6:0]  pattern_length;
        logic [1:0]  error;
    } t_out;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_TAIL
    } t_state;

endpackage

// ----- design/kmpsm_ram.sv -----
// ---------------------------------------------------------------------------
// kmpsm_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered.
// ---------------------------------------------------------------------------
module kmpsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/kmp_stream_matcher_unit.sv -----
// ---------------------------------------------------------------------------
// kmp_stream_matcher_unit
// Streaming Knuth-Morris-Pratt matcher with incremental failure-table build.
//
// Usage: drive i_item with start high; the beat is taken at an edge where
// busy is low. Each beat gives exactly one result beat on o_result, marked
// by o_valid for a single cycle; the receiver must take it then.
// A clear beat, an unused function code, an append while the store is
// full, an append of the first pattern byte and a text beat with no pattern
// finish in the accept cycle; the result is registered and shows in the next
// cycle, and busy stays low.
// An append or a text beat otherwise runs a failure-link walk in ST_WALK,
// stepping once per failure link followed; a text beat that completes an
// occurrence goes on to ST_TAIL to fetch the failure value of the full
// length. The walk is bound by the registered read of the pattern and
// failure memories, which are read once per step.
// Reset clears the loaded length, the table build prefix, the matched
// length and the text position; the memories are not cleared and entries
// beyond the loaded length are never read.
// ---------------------------------------------------------------------------
module kmp_stream_matcher_unit #(
    parameter int MAX_PATTERN   = 64,
    parameter int POSITION_BITS = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  kmpsm_pkg::t_in   i_item,
    output logic             o_valid,
    output kmpsm_pkg::t_out  o_result
);
    import kmpsm_pkg::*;

    localparam int LW  = $clog2(MAX_PATTERN + 1);
    localparam int PIW = $clog2(MAX_PATTERN);
    localparam int PB  = POSITION_BITS;
    localparam logic [LW-1:0] MAX_LEN = LW'(MAX_PATTERN);

    // state
    t_state        r_state, n_state;
    logic          r_is_text, n_is_text;
    logic [7:0]    r_byte, n_byte;
    logic [LW-1:0] r_j, n_j;
    logic [LW-1:0] r_len, n_len;
    logic [LW-1:0] r_build, n_build;
    logic [LW-1:0] r_mlen, n_mlen;
    logic [PB-1:0] r_pos, n_pos;
    logic          r_valid, n_valid;
    t_out          r_out, n_out;

    // memory ports
    logic           w_pat_we;
    logic [PIW-1:0] w_pat_waddr;
    logic [7:0]     w_pat_wdata;
    logic [7:0]     w_pat_rdata;
    logic           w_fail_we;
    logic [LW-1:0]  w_fail_waddr;
    logic [LW-1:0]  w_fail_wdata;
    logic [LW-1:0]  w_fail_rdata;
    logic [LW-1:0]  w_rd_j;

    // walk datapath
    logic           w_eq;
    logic [LW-1:0]  w_fail_clamp;
    logic [LW-1:0]  w_jn;
    logic [LW-1:0]  w_jb;
    logic [LW-1:0]  w_len_inc;
    logic [PB-1:0]  w_start_pos;
    logic [31:0]    w_start_ext;

    kmpsm_ram #(.WIDTH(8), .DEPTH(MAX_PATTERN)) u_pat_ram (
        .i_clk   (i_clk),
        .i_we    (w_pat_we),
        .i_waddr (w_pat_waddr),
        .i_wdata (w_pat_wdata),
        .i_raddr (w_rd_j[PIW-1:0]),
        .o_rdata (w_pat_rdata)
    );

    kmpsm_ram #(.WIDTH(LW), .DEPTH(MAX_PATTERN + 1)) u_fail_ram (
        .i_clk   (i_clk),
        .i_we    (w_fail_we),
        .i_waddr (w_fail_waddr),
        .i_wdata (w_fail_wdata),
        .i_raddr (w_rd_j),
        .o_rdata (w_fail_rdata)
    );

    // compare, follow link, extend
    assign w_eq         = (r_byte == w_pat_rdata);
    assign w_fail_clamp = (w_fail_rdata < r_j) ? w_fail_rdata : '0;
    assign w_jn         = r_j + LW'(w_eq);
    assign w_jb         = (w_jn > r_len) ? r_len : w_jn;
    assign w_len_inc    = r_len + LW'(1);
    assign w_start_pos  = r_pos - PB'(r_len) + PB'(1);
    assign w_start_ext  = 32'(w_start_pos);

    // state and output registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_len     <= '0;
            r_build   <= '0;
            r_mlen    <= '0;
            r_pos     <= '0;
            r_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_len     <= n_len;
            r_build   <= n_build;
            r_mlen    <= n_mlen;
            r_pos     <= n_pos;
            r_valid   <= n_valid;
        end
        r_is_text <= n_is_text;
        r_byte    <= n_byte;
        r_j       <= n_j;
        r_out     <= n_out;
    end

    // sequencer: next state, memory accesses, result beat
    always_comb begin
        n_state      = r_state;
        n_is_text    = r_is_text;
        n_byte       = r_byte;
        n_j          = r_j;
        n_len        = r_len;
        n_build      = r_build;
        n_mlen       = r_mlen;
        n_pos        = r_pos;
        n_valid      = 1'b0;
        n_out        = r_out;
        w_pat_we     = 1'b0;
        w_pat_waddr  = r_len[PIW-1:0];
        w_pat_wdata  = i_item.data_byte;
        w_fail_we    = 1'b0;
        w_fail_waddr = w_len_inc;
        w_fail_wdata = w_jb;
        w_rd_j       = r_j;

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_byte  = i_item.data_byte;
                    n_valid = 1'b1;
                    n_out   = '{match: 1'b0, match_start: '0,
                                pattern_length: 7'(r_len), error: ERR_NONE};
                    case (i_item.func)
                        FUNC_CLEAR: begin
                            n_len   = '0;
                            n_build = '0;
                            n_mlen  = '0;
                            n_pos   = '0;
                            n_out.pattern_length = '0;
                        end
                        FUNC_APPEND: begin
                            if (r_len == MAX_LEN) begin
                                n_out.error = ERR_FULL;
                            end else if (r_len == '0) begin
                                // first byte: link of length one is zero
                                w_pat_we     = 1'b1;
                                w_fail_we    = 1'b1;
                                w_fail_waddr = LW'(1);
                                w_fail_wdata = '0;
                                n_build      = '0;
                                n_len        = w_len_inc;
                                n_out.pattern_length = 7'(w_len_inc);
                            end else begin
                                w_pat_we  = 1'b1;
                                w_rd_j    = r_build;
                                n_j       = r_build;
                                n_is_text = 1'b0;
                                n_valid   = 1'b0;
                                n_state   = ST_WALK;
                            end
                        end
                        FUNC_TEXT: begin
                            if (r_len == '0) begin
                                n_out.error = ERR_EMPTY;
                            end else begin
                                w_rd_j    = r_mlen;
                                n_j       = r_mlen;
                                n_is_text = 1'b1;
                                n_valid   = 1'b0;
                                n_state   = ST_WALK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_WALK: begin
                if ((r_j != '0) && !w_eq) begin
                    // mismatch: follow the failure link, read again
                    n_j    = w_fail_clamp;
                    w_rd_j = w_fail_clamp;
                end else if (!r_is_text) begin
                    // table build: store link of the new length
                    w_fail_we = 1'b1;
                    n_build   = w_jb;
                    n_len     = w_len_inc;
                    n_valid   = 1'b1;
                    n_out     = '{match: 1'b0, match_start: '0,
                                  pattern_length: 7'(w_len_inc), error: ERR_NONE};
                    n_state   = ST_IDLE;
                end else if (w_jn >= r_len) begin
                    // full occurrence: fetch link of the full length
                    w_rd_j  = r_len;
                    n_state = ST_TAIL;
                end else begin
                    n_mlen  = w_jn;
                    n_pos   = r_pos + PB'(1);
                    n_valid = 1'b1;
                    n_out   = '{match: 1'b0, match_start: '0,
                                pattern_length: 7'(r_len), error: ERR_NONE};
                    n_state = ST_IDLE;
                end
            end
            ST_TAIL: begin
                n_mlen  = (w_fail_rdata >= r_len) ? '0 : w_fail_rdata;
                n_pos   = r_pos + PB'(1);
                n_valid = 1'b1;
                n_out   = '{match: 1'b1, match_start: w_start_ext,
                            pattern_length: 7'(r_len), error: ERR_NONE};
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_out;

    // walk index stays below the loaded length
    a_walk_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> (r_j < r_len))
        else $error("walk index reached loaded length");

    // loaded length never exceeds the store
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= MAX_LEN)
        else $error("loaded length beyond store depth");

    // matched length is a proper prefix
    a_mlen_proper: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mlen < r_len) || (r_mlen == '0))
        else $error("matched length not below loaded length");

    // tail step always reports a match next cycle
    a_tail_reports: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TAIL) |=> (o_valid && o_result.match))
        else $error("full match not reported");

    // a reported match carries no error
    a_match_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.match) |-> (o_result.error == ERR_NONE))
        else $error("match beat with error code");

endmodule

// ----- verif/kmp_match_checker.sv -----
// ---------------------------------------------------------------------------
// kmp_match_checker
// Watches the command and result channels of the KMP stream matcher. Each
// accepted command beat is run through a local model of the pattern store,
// the failure table and the text scan; the expected result beat is queued
// and compared field by field with the next result beat of the block.
// ---------------------------------------------------------------------------
module kmp_match_checker #(
    parameter int MAX_PATTERN = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_busy,
    input  kmpsm_pkg::t_in   i_item,
    input  logic             i_valid,
    input  kmpsm_pkg::t_out  i_result,
    output int               o_fail_count,
    output int               o_pending
);
    import kmpsm_pkg::*;

    localparam int PW  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int LKW = $clog2(MAX_PATTERN + 1);

    // Local copy of the matcher state
    logic [7:0]  pat_mem  [MAX_PATTERN];
    logic [6:0]  link_mem [MAX_PATTERN + 1];
    int unsigned loaded_len;
    int unsigned build_len;
    int unsigned matched_len;
    logic [31:0] text_pos;

    t_out kmp_result_q [$];
    int   fails = 0;

    function automatic logic [7:0] pat_byte(int unsigned idx);
        return (idx < MAX_PATTERN) ? pat_mem[PW'(idx)] : 8'd0;
    endfunction

    function automatic int unsigned fail_link(int unsigned idx);
        return (idx <= MAX_PATTERN) ? int'(link_mem[LKW'(idx)]) : 0;
    endfunction

    // Walk failure links until the byte extends the prefix or the prefix is empty
    function automatic int unsigned extend_prefix(int unsigned len, logic [7:0] sym);
        int unsigned j;
        int unsigned f;
        j = len;
        while (j > 0 && sym != pat_byte(j)) begin
            f = fail_link(j);
            j = (f < j) ? f : 0;
        end
        if (sym == pat_byte(j)) j++;
        return j;
    endfunction

    // Apply one command beat to the model and return the result it gives
    function automatic t_out predict_kmp_result(t_in beat);
        t_out        res;
        int unsigned i;
        int unsigned j;
        res = '0;
        case (beat.func)
            FUNC_CLEAR: begin
                loaded_len  = 0;
                build_len   = 0;
                matched_len = 0;
                text_pos    = '0;
            end
            FUNC_APPEND: begin
                if (loaded_len >= MAX_PATTERN) begin
                    res.error = ERR_FULL;
                end else begin
                    i = loaded_len;
                    pat_mem[PW'(i)] = beat.data_byte;
                    if (i == 0) begin
                        link_mem[0] = '0;
                        link_mem[1] = '0;
                        build_len   = 0;
                    end else begin
                        j = extend_prefix(build_len, beat.data_byte);
                        if (j > i) j = i;
                        link_mem[LKW'(i + 1)] = 7'(j);
                        build_len = j;
                    end
                    loaded_len = i + 1;
                end
            end
            FUNC_TEXT: begin
                if (loaded_len == 0) begin
                    res.error = ERR_EMPTY;
                end else begin
                    j = extend_prefix(matched_len, beat.data_byte);
                    if (j >= loaded_len) begin
                        res.match       = 1'b1;
                        res.match_start = text_pos - 32'(loaded_len - 1);
                        j = fail_link(loaded_len);
                        if (j >= loaded_len) j = 0;
                    end
                    matched_len = j;
                    text_pos    = text_pos + 32'd1;
                end
            end
            default: begin
            end
        endcase
        res.pattern_length = 7'(loaded_len);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        t_out got;
        if (!i_rst_n) begin
            // Hold the model in its reset state
            pat_mem     = '{default: 8'd0};
            link_mem    = '{default: 7'd0};
            loaded_len  = 0;
            build_len   = 0;
            matched_len = 0;
            text_pos    = '0;
            kmp_result_q.delete();
        end else begin
            // Compare a result beat with the oldest prediction
            if (i_valid) begin
                got = i_result;
                if (kmp_result_q.size() == 0) begin
                    $error("result beat with no command pending: %p", got);
                    fails++;
                end else begin
                    want = kmp_result_q.pop_front();
                    if (got.match !== want.match) begin
                        $error("match: expected %0d, got %0d", want.match, got.match);
                        fails++;
                    end
                    if (got.match_start !== want.match_start) begin
                        $error("match_start: expected %0d, got %0d",
                               want.match_start, got.match_start);
                        fails++;
                    end
                    if (got.pattern_length !== want.pattern_length) begin
                        $error("pattern_length: expected %0d, got %0d",
                               want.pattern_length, got.pattern_length);
                        fails++;
                    end
                    if (got.error !== want.error) begin
                        $error("error: expected %0d, got %0d", want.error, got.error);
                        fails++;
                    end
                end
            end
            // Predict the result of an accepted command beat
            if (i_start && !i_busy) kmp_result_q.push_back(predict_kmp_result(i_item));
        end
        o_fail_count <= fails;
        o_pending    <= kmp_result_q.size();
    end

endmodule

// ----- verif/tb_kmp_stream_matcher_unit.sv -----
// ---------------------------------------------------------------------------
// tb_kmp_stream_matcher_unit
// Drives command beats into the KMP stream matcher: a directed opening over
// byte extremes, overlapping hits, appends after text, an empty store, then
// random clear/pattern/text sessions over small alphabets mixed with noise
// and broken sessions, under several levels of sender idling. The checker
// beside the block predicts and compares; this module gives the verdict.
// ---------------------------------------------------------------------------
module tb_kmp_stream_matcher_unit;
    import kmpsm_pkg::*;

    localparam int          ITEM_TARGET  = 850;
    localparam int unsigned CYCLE_LIMIT  = 500000;
    localparam int          DRAIN_CYCLES = 80;
    localparam int          MAX_PATTERN  = 64;
    localparam logic [1:0]  FUNC_SPARE   = 2'd3;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_in  i_item  = '0;
    logic busy;
    logic o_valid;
    t_out o_result;

    int          fail_count;
    int          pending;
    int          idle_pct = 0;
    int          sent     = 0;
    int unsigned cycle_count = 0;
    logic [7:0]  sym_set [3];
    int          sym_count = 1;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    kmp_stream_matcher_unit #(
        .MAX_PATTERN  (MAX_PATTERN),
        .POSITION_BITS(32)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_valid (o_valid),
        .o_result(o_result)
    );

    kmp_match_checker #(
        .MAX_PATTERN(MAX_PATTERN)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_item      (i_item),
        .i_valid     (o_valid),
        .i_result    (o_result),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Offer one beat, idling at random first, and hold it until taken
    task automatic send_beat(input logic [1:0] func, input logic [7:0] data);
        t_in beat;
        beat.func      = func;
        beat.data_byte = data;
        while ($urandom_range(99) < idle_pct) begin
            start  <= 1'b0;
            i_item <= t_in'(10'($urandom_range(1023)));
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= beat;
        do @(posedge i_clk); while (busy);
        sent++;
    endtask

    // Draw a fresh small alphabet so that hits are frequent
    task automatic new_alphabet();
        sym_count = $urandom_range(1, 3);
        foreach (sym_set[k]) sym_set[k] = 8'($urandom_range(255));
    endtask

    function automatic logic [7:0] pick_sym();
        return sym_set[2'($urandom_range(sym_count - 1))];
    endfunction

    task automatic append_pattern(input int n);
        repeat (n) send_beat(FUNC_APPEND, pick_sym());
    endtask

    // Stream text over the alphabet, with sparse stray bytes and commands
    task automatic stream_text(input int n);
        int r;
        repeat (n) begin
            r = $urandom_range(99);
            if (r < 88)      send_beat(FUNC_TEXT, pick_sym());
            else if (r < 93) send_beat(FUNC_TEXT, 8'($urandom_range(255)));
            else if (r < 96) send_beat(FUNC_APPEND, pick_sym());
            else if (r < 98) send_beat(FUNC_SPARE, 8'($urandom_range(255)));
            else             send_beat(FUNC_CLEAR, 8'($urandom_range(255)));
        end
    endtask

    initial begin
        int seq_idx;
        int kind;
        int r;
        int plen;

        // Reset
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty pattern, spare code, overlapping hits, byte extremes
        send_beat(FUNC_TEXT, 8'h00);
        send_beat(FUNC_SPARE, 8'hFF);
        send_beat(FUNC_APPEND, 8'hFF);
        send_beat(FUNC_APPEND, 8'hFF);
        send_beat(FUNC_TEXT, 8'hFF);
        send_beat(FUNC_TEXT, 8'hFF);
        send_beat(FUNC_TEXT, 8'hFF);
        send_beat(FUNC_TEXT, 8'h00);
        send_beat(FUNC_TEXT, 8'hFF);
        send_beat(FUNC_TEXT, 8'hFF);
        // Append after text: matching continues with the longer pattern
        send_beat(FUNC_APPEND, 8'h00);
        send_beat(FUNC_TEXT, 8'h00);
        send_beat(FUNC_CLEAR, 8'hFF);
        send_beat(FUNC_TEXT, 8'h5A);
        send_beat(FUNC_APPEND, 8'h00);
        send_beat(FUNC_TEXT, 8'h00);
        send_beat(FUNC_TEXT, 8'h01);
        send_beat(FUNC_TEXT, 8'h00);
        send_beat(FUNC_SPARE, 8'h00);

        // Random sessions in phases of sender idling
        seq_idx = 0;
        while (sent < ITEM_TARGET) begin
            case ((seq_idx / 6) % 4)
                0:       idle_pct = 0;
                1:       idle_pct = 76;
                2:       idle_pct = 0;
                default: idle_pct = 15;
            endcase
            r = $urandom_range(99);
            if (seq_idx == 3)  kind = 1;
            else if (r < 72)   kind = 0;
            else if (r < 80)   kind = 1;
            else if (r < 90)   kind = 2;
            else               kind = 3;
            new_alphabet();
            case (kind)
                0: begin
                    // Well-formed session, sometimes extending the old pattern
                    if ($urandom_range(99) < 80)
                        send_beat(FUNC_CLEAR, 8'($urandom_range(255)));
                    r = $urandom_range(99);
                    if (r < 70)      plen = $urandom_range(1, 5);
                    else if (r < 95) plen = $urandom_range(6, 16);
                    else             plen = $urandom_range(17, 40);
                    append_pattern(plen);
                    stream_text($urandom_range(4, 40));
                end
                1: begin
                    // Fill the pattern store and push past it
                    send_beat(FUNC_CLEAR, 8'($urandom_range(255)));
                    append_pattern(MAX_PATTERN + $urandom_range(1, 3));
                    stream_text($urandom_range(10, 30));
                end
                2: begin
                    // Noise: any command, any byte
                    repeat ($urandom_range(5, 15))
                        send_beat(2'($urandom_range(3)), 8'($urandom_range(255)));
                end
                default: begin
                    // Broken session: text before pattern and a clear mid-text
                    send_beat(FUNC_CLEAR, 8'($urandom_range(255)));
                    repeat ($urandom_range(1, 3)) send_beat(FUNC_TEXT, pick_sym());
                    append_pattern($urandom_range(1, 3));
                    stream_text($urandom_range(3, 10));
                    send_beat(FUNC_CLEAR, 8'($urandom_range(255)));
                    send_beat(FUNC_TEXT, pick_sym());
                end
            endcase
            seq_idx++;
        end

        // Drop start and drain outstanding results
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ----- kmp_stream_matcher_unit.f -----
design/kmpsm_pkg.sv
design/kmpsm_ram.sv
design/kmp_stream_matcher_unit.sv
verif/kmp_match_checker.sv
verif/tb_kmp_stream_matcher_unit.sv
